// ===== rtl/hem_pkg.sv =====
// Shared types, request codes, register indexes and sequencer states of the histogram engine.
package hem_pkg;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] sample;
    logic [5:0]         read_index;
  } hem_in_t;

  typedef struct packed {
    logic [5:0]  bin_touched;
    logic [31:0] bin_count;
    logic [5:0]  peak_bin;
    logic [5:0]  lowest_bin;
  } hem_out_t;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_CLEAR  = 2'd1;
  localparam logic [1:0] REQ_FILTER = 2'd2;
  localparam logic [1:0] REQ_READ   = 2'd3;

  localparam logic [1:0] REG_RANGE_MIN  = 2'd0;
  localparam logic [1:0] REG_RANGE_MAX  = 2'd1;
  localparam logic [1:0] REG_BINS       = 2'd2;
  localparam logic [1:0] REG_RADIUS     = 2'd3;

  // Quotient bits of the bin mapping: the used bin count never exceeds 127.
  localparam int QUOT_BITS = 7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_INC_RD,
    ST_INC_WR,
    ST_MF_CAND_RD,
    ST_MF_CAND,
    ST_MF_CMP_RD,
    ST_MF_CMP,
    ST_MF_DECIDE,
    ST_CP_RD,
    ST_CP_WR,
    ST_SCAN_RD,
    ST_SCAN,
    ST_DONE
  } hem_state_e;

endpackage

// ===== rtl/hem_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hem_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/histogram_engine_median_filter.sv =====
// Histogram engine: binning with a restoring divider, median filter and argmax/argmin scan.
// Insert: multiply, 7 divide steps, read-modify-write, scan; the divide is skipped when the
//   bin needs no divide. Read and clear: scan of the used bins. Median filter: for each bin,
//   try candidates from its clipped window (at most 2*radius+1 bins) against every window
//   value, copy the medians back into the bins, then scan.
// One item at a time; the bin memory has a single read port.
// Reset is asynchronous active low: registers take their reset values and all bins read zero
// at once through per-bin valid bits, so no clearing pass runs after reset.
module histogram_engine_median_filter #(
  parameter int NUM_BINS    = 64,
  parameter int MAX_RADIUS  = 15,
  parameter int COUNT_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  hem_pkg::hem_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output hem_pkg::hem_out_t out_data_o
);
  import hem_pkg::*;

  localparam int BIN_W = $clog2(NUM_BINS);
  localparam int NW    = $clog2(NUM_BINS + 1);
  localparam int IDX_W = (NW > 6) ? NW : 6;
  localparam int WW    = NW + 5;
  localparam int CW    = COUNT_WIDTH;
  localparam int CX    = (CW > 32) ? CW : 32;

  // Configuration registers
  logic signed [15:0] range_min_q, range_max_q;
  logic [6:0]         bins_q;
  logic [3:0]         radius_q;

  hem_state_e state_q, state_d;

  logic [NUM_BINS-1:0] valid_q;
  logic                rd_ok_q;
  logic [1:0]          req_q;
  logic [IDX_W-1:0]    sel_q, pk_q, lw_q;
  logic [15:0]         d_q, span_q, rem_q;
  logic [QUOT_BITS-1:0] quot_q;
  logic [2:0]          div_cnt_q;
  logic [NW-1:0]       i_q, c_q, m_q;
  logic [WW-1:0]       lt_q, le_q;
  logic [CW-1:0]       cand_q, maxv_q, minv_q, cnt_q;
  logic                out_valid_q;
  hem_out_t            out_q;

  // Memory ports
  logic             bin_we, scr_we;
  logic [BIN_W-1:0] bin_waddr, bin_raddr, scr_waddr, scr_raddr;
  logic [CW-1:0]    bin_wdata, bin_rdata, scr_wdata, scr_rdata;

  // Derived values
  logic [NW-1:0]        n, n_last;
  logic [6:0]           n_raw, n7;
  logic [3:0]           r;
  logic signed [16:0]   span17, d17;
  logic [CW-1:0]        rd_val;
  logic [WW-1:0]        lo_cur, hi_cur, k_cur, lo_next;
  logic                 i_last, match, ins_direct;
  logic [16:0]          trial, diff17;
  logic                 ge;
  logic [22:0]          prod;
  logic [CX-1:0]        cnt_x;

  function automatic logic [WW-1:0] win_lo(input logic [NW-1:0] idx, input logic [3:0] rad);
    logic [WW-1:0] ie;
    ie = WW'(idx);
    win_lo = (ie > WW'(rad)) ? ie - WW'(rad) : '0;
  endfunction

  function automatic logic [WW-1:0] win_hi(input logic [NW-1:0] idx, input logic [3:0] rad,
                                           input logic [NW-1:0] cnt);
    logic [WW-1:0] t;
    t = WW'(idx) + WW'(rad) + WW'(1);
    win_hi = (t < WW'(cnt)) ? t : WW'(cnt);
  endfunction

  // Used bin count: zero acts as one, large values clip to the storage depth.
  assign n_raw  = (bins_q == 7'd0) ? 7'd1 : bins_q;
  assign n      = (32'(n_raw) > NUM_BINS) ? NW'(NUM_BINS) : NW'(n_raw);
  assign n7     = 7'(n);
  assign n_last = n - NW'(1);
  assign r      = (32'(radius_q) > MAX_RADIUS) ? 4'(MAX_RADIUS) : radius_q;

  assign span17 = {range_max_q[15], range_max_q} - {range_min_q[15], range_min_q};
  assign d17    = {in_data_i.sample[15], in_data_i.sample} - {range_min_q[15], range_min_q};
  // Bin 0, or the last bin when the sample lies at or beyond range_max: no divide needed.
  assign ins_direct = (span17 <= 17'sd0) || (d17 < 17'sd0) || (d17 >= span17);

  // Unwritten bins read as zero.
  assign rd_val = rd_ok_q ? bin_rdata : '0;

  assign lo_cur  = win_lo(i_q, r);
  assign hi_cur  = win_hi(i_q, r, n);
  assign k_cur   = (hi_cur - lo_cur) >> 1;
  assign lo_next = win_lo(i_q + NW'(1), r);
  assign i_last  = (i_q == n_last);
  // The candidate is the median when exactly k window values sort before its slot.
  assign match   = (lt_q <= k_cur) && (k_cur < le_q);

  // Restoring divide step: one quotient bit per cycle.
  assign trial  = {rem_q, quot_q[QUOT_BITS-1]};
  assign ge     = (trial >= {1'b0, span_q});
  assign diff17 = trial - {1'b0, span_q};
  assign prod   = 23'(d_q * n7);

  assign cnt_x = CX'(cnt_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_data_i.req_type)
            REQ_INSERT: state_d = ins_direct ? ST_INC_RD : ST_MUL;
            REQ_FILTER: state_d = ST_MF_CAND_RD;
            default:    state_d = ST_SCAN_RD;
          endcase
        end
      end
      ST_MUL:        state_d = ST_DIV;
      ST_DIV: begin
        if (div_cnt_q == 3'(QUOT_BITS - 1)) begin
          state_d = ST_INC_RD;
        end
      end
      ST_INC_RD:     state_d = ST_INC_WR;
      ST_INC_WR:     state_d = ST_SCAN_RD;
      ST_MF_CAND_RD: state_d = ST_MF_CAND;
      ST_MF_CAND:    state_d = ST_MF_CMP_RD;
      ST_MF_CMP_RD:  state_d = ST_MF_CMP;
      ST_MF_CMP: begin
        state_d = (WW'(m_q) + WW'(1) == hi_cur) ? ST_MF_DECIDE : ST_MF_CMP_RD;
      end
      ST_MF_DECIDE: begin
        state_d = (match && i_last) ? ST_CP_RD : ST_MF_CAND_RD;
      end
      ST_CP_RD:      state_d = ST_CP_WR;
      ST_CP_WR:      state_d = i_last ? ST_SCAN_RD : ST_CP_RD;
      ST_SCAN_RD:    state_d = ST_SCAN;
      ST_SCAN:       state_d = i_last ? ST_DONE : ST_SCAN_RD;
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default:       state_d = ST_IDLE;
    endcase
  end

  // Memory controls
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    bin_we     = 1'b0;
    bin_waddr  = sel_q[BIN_W-1:0];
    bin_wdata  = (rd_val == {CW{1'b1}}) ? rd_val : rd_val + CW'(1);
    bin_raddr  = '0;
    scr_we     = 1'b0;
    scr_waddr  = i_q[BIN_W-1:0];
    scr_wdata  = cand_q;
    scr_raddr  = i_q[BIN_W-1:0];
    unique case (state_q)
      ST_INC_RD:     bin_raddr = sel_q[BIN_W-1:0];
      ST_INC_WR:     bin_we    = 1'b1;
      ST_MF_CAND_RD: bin_raddr = c_q[BIN_W-1:0];
      ST_MF_CMP_RD:  bin_raddr = m_q[BIN_W-1:0];
      ST_MF_DECIDE:  scr_we    = match;
      ST_CP_WR: begin
        bin_we    = 1'b1;
        bin_waddr = i_q[BIN_W-1:0];
        bin_wdata = scr_rdata;
      end
      ST_SCAN_RD:    bin_raddr = i_q[BIN_W-1:0];
      default: begin
      end
    endcase
  end

  // State and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      range_min_q <= 16'sd0;
      range_max_q <= 16'sd32767;
      bins_q      <= 7'd64;
      radius_q    <= 4'd1;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_RANGE_MIN: range_min_q <= cfg_wdata_i;
          REG_RANGE_MAX: range_max_q <= cfg_wdata_i;
          REG_BINS:      bins_q      <= cfg_wdata_i[6:0];
          REG_RADIUS:    radius_q    <= cfg_wdata_i[3:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Per-bin valid bits: a write sets one, clear and resize drop them all.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      rd_ok_q <= valid_q[bin_raddr];
      if ((cfg_we_i && cfg_idx_i == REG_BINS) ||
          (state_q == ST_IDLE && in_valid_i && in_data_i.req_type == REQ_CLEAR)) begin
        valid_q <= '0;
      end else if (bin_we) begin
        valid_q[bin_waddr] <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        req_q  <= in_data_i.req_type;
        d_q    <= d17[15:0];
        span_q <= span17[15:0];
        i_q    <= '0;
        c_q    <= '0;
        cnt_q  <= '0;
        if (in_data_i.req_type == REQ_READ) begin
          sel_q <= IDX_W'(in_data_i.read_index);
        end else if (in_data_i.req_type == REQ_INSERT && ins_direct && span17 > 17'sd0 &&
                     d17 >= 17'sd0) begin
          sel_q <= IDX_W'(n_last);
        end else begin
          sel_q <= '0;
        end
      end
      ST_MUL: begin
        // d < span and n < 128 keep the top bits below the divisor.
        rem_q     <= prod[22:QUOT_BITS];
        quot_q    <= prod[QUOT_BITS-1:0];
        div_cnt_q <= '0;
      end
      ST_DIV: begin
        rem_q     <= ge ? diff17[15:0] : trial[15:0];
        quot_q    <= {quot_q[QUOT_BITS-2:0], ge};
        div_cnt_q <= div_cnt_q + 3'd1;
        if (div_cnt_q == 3'(QUOT_BITS - 1)) begin
          sel_q <= IDX_W'({quot_q[QUOT_BITS-2:0], ge});
        end
      end
      ST_INC_WR: i_q <= '0;
      ST_MF_CAND: begin
        cand_q <= rd_val;
        m_q    <= NW'(lo_cur);
        lt_q   <= '0;
        le_q   <= '0;
      end
      ST_MF_CMP: begin
        if (rd_val < cand_q) begin
          lt_q <= lt_q + WW'(1);
        end
        if (rd_val <= cand_q) begin
          le_q <= le_q + WW'(1);
        end
        m_q <= m_q + NW'(1);
      end
      ST_MF_DECIDE: begin
        if (match) begin
          if (i_last) begin
            i_q <= '0;
          end else begin
            i_q <= i_q + NW'(1);
            c_q <= NW'(lo_next);
          end
        end else begin
          c_q <= c_q + NW'(1);
        end
      end
      ST_CP_WR: i_q <= i_last ? '0 : i_q + NW'(1);
      ST_SCAN: begin
        if (i_q == '0) begin
          maxv_q <= rd_val;
          minv_q <= rd_val;
          pk_q   <= '0;
          lw_q   <= '0;
        end else begin
          if (rd_val > maxv_q) begin
            maxv_q <= rd_val;
            pk_q   <= IDX_W'(i_q);
          end
          if (rd_val < minv_q) begin
            minv_q <= rd_val;
            lw_q   <= IDX_W'(i_q);
          end
        end
        if (IDX_W'(i_q) == sel_q) begin
          cnt_q <= rd_val;
        end
        if (!i_last) begin
          i_q <= i_q + NW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: hold a beat until taken, load the next one as it leaves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) begin
      out_q.bin_touched <= (req_q == REQ_INSERT || req_q == REQ_READ) ? sel_q[5:0] : 6'd0;
      out_q.bin_count   <= cnt_x[31:0];
      out_q.peak_bin    <= pk_q[5:0];
      out_q.lowest_bin  <= lw_q[5:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  hem_ram #(.WIDTH(CW), .DEPTH(NUM_BINS)) u_bins (
    .clk_i   (clk_i),
    .we_i    (bin_we),
    .waddr_i (bin_waddr),
    .wdata_i (bin_wdata),
    .raddr_i (bin_raddr),
    .rdata_o (bin_rdata)
  );

  hem_ram #(.WIDTH(CW), .DEPTH(NUM_BINS)) u_scratch (
    .clk_i   (clk_i),
    .we_i    (scr_we),
    .waddr_i (scr_waddr),
    .wdata_i (scr_wdata),
    .raddr_i (scr_raddr),
    .rdata_o (scr_rdata)
  );

  // A pending beat is never overwritten by a finished item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && out_stall_i) |=> (state_q == ST_DONE))
    else $error("finished item left while output beat was stalled");

  // The mapped bin of an insert stays inside the used bins.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INC_RD) |-> (sel_q < IDX_W'(n)))
    else $error("insert bin out of range");

  // A median candidate always lies inside the clipped window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MF_CAND) |-> (WW'(c_q) >= lo_cur && WW'(c_q) < hi_cur))
    else $error("median candidate outside window");

  // The scan only reports used bins.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (pk_q < IDX_W'(n) && lw_q < IDX_W'(n)))
    else $error("argmax or argmin beyond used bins");

endmodule
